### rtl/tdf_pkg.sv
// Shared constants and types of the trial division factoriser.
`default_nettype none

package tdf_pkg;

    localparam int VALUE_BITS  = 31;
    localparam int MAX_FACTORS = 30;
    localparam int IDX_BITS    = 5;
    localparam int CNT_BITS    = $clog2(VALUE_BITS);
    localparam int NUM_BITS    = $clog2(MAX_FACTORS + 1);

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [IDX_BITS-1:0]   index_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIV   = 4'b0010,
        S_CHECK = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

endpackage

`default_nettype wire

### rtl/tdf_if.sv
// Valid/ready channel interfaces for the factoriser input and result streams.
`default_nettype none

interface tdf_in_if
    import tdf_pkg::*;
();
    logic   valid;
    logic   ready;
    value_t value_in;

    modport source (output valid, output value_in, input ready);
    modport sink   (input valid, input value_in, output ready);
endinterface

interface tdf_out_if
    import tdf_pkg::*;
();
    logic   valid;
    logic   ready;
    value_t prime_factor;
    index_t factor_index;
    logic   is_last;

    modport source (output valid, output prime_factor, output factor_index,
                    output is_last, input ready);
    modport sink   (input valid, input prime_factor, input factor_index,
                    input is_last, output ready);
endinterface

`default_nettype wire

### rtl/trial_division_factorizer_core.sv
// Trial division prime factoriser with a bit-serial restoring divider.
//
// Usage: one value is taken on in_ch (valid/ready transfer) while the core is
// idle. Its prime factors leave on out_ch in ascending order, with repeats,
// one transfer per factor; factor_index counts from 0 and is_last marks the
// final factor. An input of 0 or 1 yields a single result with factor 0,
// index 0 and is_last set.
// Timing: every trial divisor costs one pass of the shared divider, which
// retires one quotient bit per cycle, followed by a decision step. A run tries
// divisors up to the square root of the remaining value. A new input is
// taken once the last result sits in the output register, even while the
// receiver has not yet taken it.
// Stall: a full output register that the receiver does not take holds the
// core in its emit step; nothing is dropped.
// Reset (rst_n low, asynchronous): the core returns to idle and the output
// register is emptied.
`default_nettype none

module trial_division_factorizer_core
    import tdf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    tdf_in_if.sink      in_ch,
    tdf_out_if.source   out_ch
);

    state_t                state_reg, state_next;
    value_t                rem_reg, rem_next;
    value_t                d_reg, d_next;
    value_t                dq_reg, dq_next;
    value_t                acc_reg, acc_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [NUM_BITS-1:0]   n_reg, n_next;
    value_t                pend_factor_reg, pend_factor_next;
    logic                  pend_last_reg, pend_last_next;

    logic                  out_valid_reg, out_valid_next;
    value_t                out_factor_reg, out_factor_next;
    index_t                out_index_reg, out_index_next;
    logic                  out_last_reg, out_last_next;

    logic [VALUE_BITS:0]   trial;
    logic [VALUE_BITS:0]   diff;
    logic                  out_free;
    logic                  in_xfer;
    logic                  out_xfer;

    assign trial    = {acc_reg, dq_reg[VALUE_BITS-1]};
    assign diff     = trial - {1'b0, d_reg};
    assign out_free = !out_valid_reg || out_ch.ready;
    assign in_xfer  = in_ch.valid && in_ch.ready;
    assign out_xfer = out_valid_reg && out_ch.ready;

    assign in_ch.ready         = (state_reg == S_IDLE);
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.prime_factor = out_factor_reg;
    assign out_ch.factor_index = out_index_reg;
    assign out_ch.is_last      = out_last_reg;

    always_comb
    begin
        state_next       = state_reg;
        rem_next         = rem_reg;
        d_next           = d_reg;
        dq_next          = dq_reg;
        acc_next         = acc_reg;
        cnt_next         = cnt_reg;
        n_next           = n_reg;
        pend_factor_next = pend_factor_reg;
        pend_last_next   = pend_last_reg;
        out_valid_next   = out_valid_reg && !out_ch.ready;
        out_factor_next  = out_factor_reg;
        out_index_next   = out_index_reg;
        out_last_next    = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    n_next = '0;
                    d_next = value_t'(2);
                    if (in_ch.value_in < value_t'(2))
                    begin
                        rem_next         = in_ch.value_in;
                        pend_factor_next = '0;
                        pend_last_next   = 1'b1;
                        state_next       = S_EMIT;
                    end
                    else
                    begin
                        rem_next   = in_ch.value_in;
                        dq_next    = in_ch.value_in;
                        acc_next   = '0;
                        cnt_next   = CNT_BITS'(VALUE_BITS - 1);
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                // one restoring step: keep the difference unless it borrowed
                if (!diff[VALUE_BITS])
                    acc_next = diff[VALUE_BITS-1:0];
                else
                    acc_next = trial[VALUE_BITS-1:0];
                dq_next  = {dq_reg[VALUE_BITS-2:0], !diff[VALUE_BITS]};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                priority if (d_reg > dq_reg)
                begin
                    // divisor squared exceeds the remainder: it is prime
                    pend_factor_next = rem_reg;
                    pend_last_next   = 1'b1;
                    rem_next         = value_t'(1);
                    state_next       = S_EMIT;
                end
                else if (acc_reg == '0)
                begin
                    pend_factor_next = d_reg;
                    pend_last_next   = (dq_reg == value_t'(1)) ||
                                       (n_reg == NUM_BITS'(MAX_FACTORS - 1));
                    rem_next         = dq_reg;
                    state_next       = S_EMIT;
                end
                else
                begin
                    d_next     = d_reg + value_t'(1);
                    dq_next    = rem_reg;
                    acc_next   = '0;
                    cnt_next   = CNT_BITS'(VALUE_BITS - 1);
                    state_next = S_DIV;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_factor_next = pend_factor_reg;
                    out_index_next  = IDX_BITS'(n_reg);
                    out_last_next   = pend_last_reg;
                    if (pend_factor_reg != '0)
                        n_next = n_reg + 1'b1;
                    if (pend_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // same divisor again on the quotient
                        dq_next    = rem_reg;
                        acc_next   = '0;
                        cnt_next   = CNT_BITS'(VALUE_BITS - 1);
                        state_next = S_DIV;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            n_reg         <= '0;
            cnt_reg       <= '0;
            d_reg         <= value_t'(2);
            rem_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            n_reg         <= n_next;
            cnt_reg       <= cnt_next;
            d_reg         <= d_next;
            rem_reg       <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg          <= dq_next;
        acc_reg         <= acc_next;
        pend_factor_reg <= pend_factor_next;
        pend_last_reg   <= pend_last_next;
        out_factor_reg  <= out_factor_next;
        out_index_reg   <= out_index_next;
        out_last_reg    <= out_last_next;
    end

    a_div_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (acc_reg < d_reg))
        else $error("partial remainder not below divisor");

    a_divisor_at_least_two: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (d_reg >= value_t'(2)))
        else $error("trial divisor below two during a run");

    a_run_open_after_non_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && !out_last_reg) |-> (state_reg != S_IDLE))
        else $error("run closed before its last factor");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (n_reg == '0))
        else $error("factor count not cleared at input transfer");

endmodule

`default_nettype wire
